FILE: design/assert_macros.svh
// Assertion macros shared by the gamepad event detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: design/gced_pkg.sv
// Shared types, constants and helper functions of the gamepad event detector
package gced_pkg;

   // Register reset values
   localparam logic [15:0] DEAD_ZONE_RESET         = 16'd1639;
   localparam logic [15:0] CHANGE_THRESHOLD_RESET  = 16'd327;
   localparam logic [7:0]  TRIGGER_THRESHOLD_RESET = 8'd127;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_DEAD_ZONE         = 2'd0,
      CSR_CHANGE_THRESHOLD  = 2'd1,
      CSR_TRIGGER_THRESHOLD = 2'd2
   } csr_idx_type;

   // Event kinds on the result channel
   typedef enum logic [1:0] {
      KIND_CONNECT    = 2'd0,
      KIND_DISCONNECT = 2'd1,
      KIND_AXIS       = 2'd2,
      KIND_BUTTON     = 2'd3
   } kind_type;

   // Positions in the per-poll event mask, in output order
   localparam int NUM_EVENTS    = 22;
   localparam int EV_CONNECT    = 0;
   localparam int EV_DISCONNECT = 1;
   localparam int EV_AXIS0      = 2;
   localparam int EV_BUTTON0    = 6;
   localparam int EV_POS_W      = $clog2(NUM_EVENTS);

   // One classified poll as it travels from front to back
   typedef struct packed {
      logic [NUM_EVENTS-1:0] ev_mask;
      logic [3:0][15:0]      axis_val;
      logic [15:0]           pressed;
   } record_type;

   // Raw bit feeding each logical button 0..13
   localparam logic [3:0] BUTTON_MAP [14] = '{
      4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd5,
      4'd4,  4'd6,  4'd7,  4'd0,  4'd1, 4'd2, 4'd3
   };

   // Reorder the raw button word into logical buttons 0..13
   function automatic logic [13:0] map_buttons(input logic [15:0] raw);
      logic [13:0] res;
      for (int i = 0; i < 14; i++) begin
         res[i] = raw[BUTTON_MAP[i]];
      end
      return res;
   endfunction

   // Zero an axis count whose magnitude is strictly below the dead zone
   function automatic logic [15:0] apply_dead_zone(input logic [15:0] v,
                                                   input logic [15:0] dz);
      logic [16:0] mag;
      mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
      return (mag < {1'b0, dz}) ? 16'd0 : v;
   endfunction

   // Absolute difference of two signed 16-bit counts compared to a threshold
   function automatic logic moved_beyond(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] thr);
      logic [16:0] diff;
      logic [16:0] mag;
      diff = {a[15], a} - {b[15], b};
      mag  = diff[16] ? (17'd0 - diff) : diff;
      return mag > {1'b0, thr};
   endfunction

endpackage

FILE: design/gced_req_if.sv
// Poll request channel of the gamepad event detector
interface gced_req_if;
   logic        valid;
   logic        ready;
   logic        poll_ok;
   logic [15:0] left_x;
   logic [15:0] left_y;
   logic [15:0] right_x;
   logic [15:0] right_y;
   logic [15:0] button_bits;
   logic [7:0]  left_pull;
   logic [7:0]  right_pull;

   modport source (output valid, poll_ok, left_x, left_y, right_x, right_y,
                   button_bits, left_pull, right_pull, input ready);
   modport sink   (input valid, poll_ok, left_x, left_y, right_x, right_y,
                   button_bits, left_pull, right_pull, output ready);
endinterface

FILE: design/gced_rsp_if.sv
// Event result channel of the gamepad event detector
interface gced_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [3:0]  event_index;
   logic [15:0] axis_value;
   logic        pressed;
   logic        last_of_poll;

   modport source (output valid, event_kind, event_index, axis_value, pressed,
                   last_of_poll, input ready);
   modport sink   (input valid, event_kind, event_index, axis_value, pressed,
                   last_of_poll, output ready);
endinterface

FILE: design/gced_csr_if.sv
// Configuration write channel of the gamepad event detector
interface gced_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  idx;
   logic [15:0] wdata;

   modport source (output valid, idx, wdata, input ready);
   modport sink   (input valid, idx, wdata, output ready);
endinterface

FILE: design/gamepad_change_event_detector_unit.sv
// Top level of the gamepad change-event detector
//
// Channels: req_if takes one controller poll per handshake, rsp_if returns
// the change events of that poll one per handshake, in order: connect or
// disconnect, axis events 0..3, button events 0..15 (14, 15 are triggers).
// last_of_poll marks the final event of a poll; a poll with no change
// returns nothing. csr_if writes dead_zone (0), change_threshold (1) and
// trigger_threshold (2); it is always ready and other indexes are dropped.
// Path: with the queue empty and the result register free, the first event
// of a poll is written to the queue and then loaded into the result register.
// Throughput: one event per cycle while rsp_if.ready is high, up to 21
// events per poll; polls without events are not queued. The event queue
// between the classifier and the serializer sets how far the request side
// can run ahead.
// Reset: registers return to their defaults, the pad reads as not
// connected, the stored sample is zero and the queue is empty.
// Stall: while rsp_if.ready is low the current event holds; the request
// side keeps taking polls until the queue fills.
module gamepad_change_event_detector_unit #(
   parameter int QueueDepth = gced_pkg::QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   gced_req_if.sink   req_if,
   gced_csr_if.sink   csr_if,
   gced_rsp_if.source rsp_if
);
   import gced_pkg::*;

   logic       q_push, q_pop, q_full, q_empty;
   record_type q_rec, q_head;

   // Classify polls and keep the sample state
   gced_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .csr_if (csr_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_rec  (q_rec)
   );

   // Buffer classified polls
   gced_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Serialize events onto the result channel
   gced_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .empty  (q_empty),
      .pop    (q_pop),
      .rsp_if (rsp_if)
   );

endmodule

FILE: design/gced_front.sv
// Front end: configuration registers, poll classification and sample state
`include "assert_macros.svh"
module gced_front (
   input  logic                clock,
   input  logic                reset,
   gced_req_if.sink            req_if,
   gced_csr_if.sink            csr_if,
   input  logic                q_full,
   output logic                q_push,
   output gced_pkg::record_type q_rec
);
   import gced_pkg::*;

   logic [15:0] dead_zone_ff, dead_zone_in;
   logic [15:0] change_thr_ff, change_thr_in;
   logic [7:0]  trigger_thr_ff, trigger_thr_in;

   logic            connected_ff, connected_in;
   logic [3:0][15:0] prev_axes_ff, prev_axes_in;
   logic [15:0]     prev_buttons_ff, prev_buttons_in;
   logic [1:0][7:0] prev_trig_ff, prev_trig_in;

   logic            accept;
   logic [3:0][15:0] cur_raw;
   logic [3:0][15:0] cur_dz;
   logic [3:0]      axis_hit;
   logic [13:0]     btn_now, btn_was;
   logic [1:0]      trig_now, trig_was;
   record_type      rec;

   assign req_if.ready = !q_full;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      dead_zone_in   = dead_zone_ff;
      change_thr_in  = change_thr_ff;
      trigger_thr_in = trigger_thr_ff;
      if (csr_if.valid) begin
         unique case (csr_idx_type'(csr_if.idx))
            CSR_DEAD_ZONE:         dead_zone_in   = csr_if.wdata;
            CSR_CHANGE_THRESHOLD:  change_thr_in  = csr_if.wdata;
            CSR_TRIGGER_THRESHOLD: trigger_thr_in = csr_if.wdata[7:0];
            default:               ;
         endcase
      end
   end

   // Classify the poll against the stored sample
   always_comb begin
      cur_raw[0] = req_if.left_x;
      cur_raw[1] = req_if.left_y;
      cur_raw[2] = req_if.right_x;
      cur_raw[3] = req_if.right_y;
      for (int i = 0; i < 4; i++) begin
         cur_dz[i]   = apply_dead_zone(cur_raw[i], dead_zone_ff);
         axis_hit[i] = moved_beyond(cur_dz[i],
                                    apply_dead_zone(prev_axes_ff[i], dead_zone_ff),
                                    change_thr_ff);
      end
      btn_now     = map_buttons(req_if.button_bits);
      btn_was     = map_buttons(prev_buttons_ff);
      trig_now[0] = req_if.left_pull > trigger_thr_ff;
      trig_now[1] = req_if.right_pull > trigger_thr_ff;
      trig_was[0] = prev_trig_ff[0] > trigger_thr_ff;
      trig_was[1] = prev_trig_ff[1] > trigger_thr_ff;

      rec.ev_mask  = '0;
      rec.axis_val = cur_dz;
      rec.pressed  = {trig_now, btn_now};
      if (!req_if.poll_ok) begin
         rec.ev_mask[EV_DISCONNECT] = connected_ff;
      end else begin
         rec.ev_mask[EV_CONNECT] = !connected_ff;
         rec.ev_mask[EV_BUTTON0-1:EV_AXIS0] = axis_hit;
         rec.ev_mask[NUM_EVENTS-1:EV_BUTTON0] = {trig_now ^ trig_was, btn_now ^ btn_was};
      end
   end

   assign q_rec  = rec;
   assign q_push = accept && (rec.ev_mask != '0);

   // Advance the stored sample on an accepted poll; a failed poll keeps it
   always_comb begin
      connected_in    = connected_ff;
      prev_axes_in    = prev_axes_ff;
      prev_buttons_in = prev_buttons_ff;
      prev_trig_in    = prev_trig_ff;
      if (accept) begin
         connected_in = req_if.poll_ok;
         if (req_if.poll_ok) begin
            prev_axes_in    = cur_raw;
            prev_buttons_in = req_if.button_bits;
            prev_trig_in    = {req_if.right_pull, req_if.left_pull};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff    <= DEAD_ZONE_RESET;
         change_thr_ff   <= CHANGE_THRESHOLD_RESET;
         trigger_thr_ff  <= TRIGGER_THRESHOLD_RESET;
         connected_ff    <= 1'b0;
         prev_axes_ff    <= '0;
         prev_buttons_ff <= '0;
         prev_trig_ff    <= '0;
      end else begin
         dead_zone_ff    <= dead_zone_in;
         change_thr_ff   <= change_thr_in;
         trigger_thr_ff  <= trigger_thr_in;
         connected_ff    <= connected_in;
         prev_axes_ff    <= prev_axes_in;
         prev_buttons_ff <= prev_buttons_in;
         prev_trig_ff    <= prev_trig_in;
      end
   end

   `ASSERT_NEVER(a_conn_and_disc, clock, reset, q_push && rec.ev_mask[EV_CONNECT] && rec.ev_mask[EV_DISCONNECT])

endmodule

FILE: design/gced_queue.sv
// Short queue of classified polls between front and back
`include "assert_macros.svh"
module gced_queue #(
   parameter int Depth = gced_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gced_pkg::record_type push_rec,
   input  logic                 pop,
   output gced_pkg::record_type head,
   output logic                 full,
   output logic                 empty
);
   import gced_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   record_type        mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push && full)
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty)

endmodule

FILE: design/gced_back.sv
// Back end: serialize the events of the head record onto the result channel
`include "assert_macros.svh"
module gced_back (
   input  logic                 clock,
   input  logic                 reset,
   input  gced_pkg::record_type head,
   input  logic                 empty,
   output logic                 pop,
   gced_rsp_if.source           rsp_if
);
   import gced_pkg::*;

   logic [NUM_EVENTS-1:0] sent_ff, sent_in;
   logic [NUM_EVENTS-1:0] remaining, bit_sel, rest;
   logic [EV_POS_W-1:0]   pos;
   logic [EV_POS_W-1:0]   axis_off, btn_off;
   logic                  load;

   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [3:0]  index_ff, index_in;
   logic [15:0] axis_ff, axis_in;
   logic        pressed_ff, pressed_in;
   logic        last_ff, last_in;

   // Pick the lowest pending event of the head record
   always_comb begin
      remaining = head.ev_mask & ~sent_ff;
      bit_sel   = remaining & (~remaining + 1'b1);
      rest      = remaining & ~bit_sel;
      pos       = '0;
      for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            pos = EV_POS_W'(i);
         end
      end
      axis_off = pos - EV_POS_W'(EV_AXIS0);
      btn_off  = pos - EV_POS_W'(EV_BUTTON0);
   end

   // Load the output register when it is free or being drained
   assign load = !empty && (!valid_ff || rsp_if.ready);
   assign pop  = load && (rest == '0);

   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = '0;
      end else if (load) begin
         sent_in = sent_ff | bit_sel;
      end
   end

   // Build the next event
   always_comb begin
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      index_in   = index_ff;
      axis_in    = axis_ff;
      pressed_in = pressed_ff;
      last_in    = last_ff;
      if (load) begin
         valid_in   = 1'b1;
         last_in    = (rest == '0);
         index_in   = '0;
         axis_in    = '0;
         pressed_in = 1'b0;
         if (pos == EV_POS_W'(EV_CONNECT)) begin
            kind_in = KIND_CONNECT;
         end else if (pos == EV_POS_W'(EV_DISCONNECT)) begin
            kind_in = KIND_DISCONNECT;
         end else if (pos < EV_POS_W'(EV_BUTTON0)) begin
            kind_in  = KIND_AXIS;
            index_in = 4'(axis_off);
            axis_in  = head.axis_val[axis_off[1:0]];
         end else begin
            kind_in    = KIND_BUTTON;
            index_in   = 4'(btn_off);
            pressed_in = head.pressed[btn_off[3:0]];
         end
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      index_ff   <= index_in;
      axis_ff    <= axis_in;
      pressed_ff <= pressed_in;
      last_ff    <= last_in;
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.event_kind   = kind_ff;
   assign rsp_if.event_index  = index_ff;
   assign rsp_if.axis_value   = axis_ff;
   assign rsp_if.pressed      = pressed_ff;
   assign rsp_if.last_of_poll = last_ff;

   `ASSERT_AT(a_head_pending, clock, reset, !empty |-> remaining != '0)
   `ASSERT_AT(a_pick_onehot, clock, reset, $onehot0(bit_sel))

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the gamepad change-event detector
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gced_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [1:0] CSR_UNUSED_IDX = 2'd3;
   // Raw button bit behind each logical button 0..13
   localparam int RAW_BIT_OF [14] = '{12, 13, 14, 15, 8, 9, 5, 4, 6, 7, 0, 1, 2, 3};

   typedef struct packed {
      logic            poll_ok;
      logic [3:0][15:0] axis;
      logic [15:0]     buttons;
      logic [1:0][7:0] pull;
   } poll_t;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  index;
      logic [15:0] value;
      logic        pressed;
      logic        last;
   } pad_event_t;

   logic clock;
   logic reset;

   gced_req_if req_if ();
   gced_rsp_if rsp_if ();
   gced_csr_if csr_if ();

   gamepad_change_event_detector_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .csr_if (csr_if),
      .rsp_if (rsp_if)
   );

   poll_t      poll_queue [$];
   pad_event_t owed_events [$];

   int send_idle_pct;
   int recv_idle_pct;
   int polls_pushed;
   int polls_taken;
   int events_checked;
   int csr_writes;
   int settings_used;
   int failures;
   int cycle_count;

   // Shadow of the detector: registers and stored sample
   logic [15:0]      cfg_dead_zone;
   logic [15:0]      cfg_change_thr;
   logic [7:0]       cfg_trigger_thr;
   logic             pad_connected;
   logic [3:0][15:0] last_axis;
   logic [15:0]      last_buttons;
   logic [1:0][7:0]  last_pull;

   // Stimulus shaping: last generated poll and the settings being aimed at
   poll_t gen_last;
   int    aim_dz;
   int    aim_tt;

   // Free-running clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // Zero a count whose magnitude lies strictly inside the dead zone
   function automatic int zone_count(logic [15:0] raw);
      int v;
      int mag;
      v = int'($signed(raw));
      mag = (v < 0) ? -v : v;
      return (mag < int'(cfg_dead_zone)) ? 0 : v;
   endfunction

   function automatic pad_event_t make_event(kind_type k, int idx, int v, logic pr);
      pad_event_t e;
      e.kind = k;
      e.index = 4'(idx);
      e.value = 16'(v);
      e.pressed = pr;
      e.last = 1'b0;
      return e;
   endfunction

   // Work out the events of one accepted poll and advance the shadow state
   function automatic void derive_events(poll_t p);
      pad_event_t evs [$];
      int cur;
      int prv;
      int diff;
      logic was_on;
      logic is_on;
      if (!p.poll_ok) begin
         if (pad_connected) begin
            pad_connected = 1'b0;
            evs.push_back(make_event(KIND_DISCONNECT, 0, 0, 1'b0));
         end
      end else begin
         if (!pad_connected) begin
            pad_connected = 1'b1;
            evs.push_back(make_event(KIND_CONNECT, 0, 0, 1'b0));
         end
         for (int i = 0; i < 4; i++) begin
            cur = zone_count(p.axis[i]);
            prv = zone_count(last_axis[i]);
            diff = (cur > prv) ? cur - prv : prv - cur;
            if (diff > int'(cfg_change_thr)) begin
               evs.push_back(make_event(KIND_AXIS, i, cur, 1'b0));
            end
         end
         for (int i = 0; i < 14; i++) begin
            was_on = last_buttons[RAW_BIT_OF[i]];
            is_on = p.buttons[RAW_BIT_OF[i]];
            if (was_on != is_on) begin
               evs.push_back(make_event(KIND_BUTTON, i, 0, is_on));
            end
         end
         for (int i = 0; i < 2; i++) begin
            was_on = last_pull[i] > cfg_trigger_thr;
            is_on = p.pull[i] > cfg_trigger_thr;
            if (was_on != is_on) begin
               evs.push_back(make_event(KIND_BUTTON, 14 + i, 0, is_on));
            end
         end
         last_axis = p.axis;
         last_buttons = p.buttons;
         last_pull = p.pull;
      end
      if (evs.size() != 0) begin
         evs[evs.size() - 1].last = 1'b1;
      end
      foreach (evs[i]) begin
         owed_events.push_back(evs[i]);
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic poll_t mk_poll(logic ok, logic [15:0] a0, logic [15:0] a1,
                                     logic [15:0] a2, logic [15:0] a3,
                                     logic [15:0] btn, logic [7:0] lp, logic [7:0] rp);
      poll_t p;
      p.poll_ok = ok;
      p.axis[0] = a0;
      p.axis[1] = a1;
      p.axis[2] = a2;
      p.axis[3] = a3;
      p.buttons = btn;
      p.pull[0] = lp;
      p.pull[1] = rp;
      return p;
   endfunction

   // Pick an axis count: wide random, extremes, dead-zone edge, held, nudged or small random
   function automatic logic [15:0] pick_axis(logic [15:0] prior);
      int base;
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         2: begin
            base = aim_dz + $urandom_range(0, 2) - 1;
            return ($urandom_range(0, 1) != 0) ? 16'(base) : 16'(-base);
         end
         3: return prior;
         4: return prior + 16'($urandom_range(0, 1200)) - 16'd600;
         default: return 16'($urandom_range(0, 4000)) - 16'd2000;
      endcase
   endfunction

   function automatic logic [7:0] pick_pull(logic [7:0] prior);
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(0, 255));
         1: return 8'(aim_tt + $urandom_range(0, 2) - 1);
         default: return prior;
      endcase
   endfunction

   function automatic poll_t random_poll();
      poll_t p;
      p.poll_ok = ($urandom_range(0, 99) < 88);
      for (int i = 0; i < 4; i++) begin
         p.axis[i] = pick_axis(gen_last.axis[i]);
      end
      case ($urandom_range(0, 3))
         0: p.buttons = 16'($urandom);
         1: p.buttons = gen_last.buttons ^ (16'd1 << $urandom_range(0, 15));
         2: p.buttons = gen_last.buttons;
         default: p.buttons = gen_last.buttons ^ (16'($urandom) & 16'($urandom));
      endcase
      p.pull[0] = pick_pull(gen_last.pull[0]);
      p.pull[1] = pick_pull(gen_last.pull[1]);
      return p;
   endfunction

   function automatic void push_poll(poll_t p);
      poll_queue.push_back(p);
      polls_pushed++;
      gen_last = p;
   endfunction

   // Drive one register write and hold it until the port takes it
   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.idx <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Wait until every request is taken and every event has come back
   task automatic wait_quiet();
      while (polls_taken != polls_pushed || owed_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int count, int dz, int ct, int tt);
      aim_dz = dz & 16'hFFFF;
      aim_tt = tt & 8'hFF;
      write_csr(CSR_DEAD_ZONE, 16'(dz));
      write_csr(CSR_CHANGE_THRESHOLD, 16'(ct));
      write_csr(CSR_TRIGGER_THRESHOLD, 16'(tt));
      settings_used++;
      for (int i = 0; i < count; i++) begin
         push_poll(random_poll());
      end
      wait_quiet();
   endtask

   // Request driver: load the next poll once the current one is taken
   always @(posedge clock) begin : driver
      poll_t nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (poll_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = poll_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.poll_ok <= nxt.poll_ok;
            req_if.left_x <= nxt.axis[0];
            req_if.left_y <= nxt.axis[1];
            req_if.right_x <= nxt.axis[2];
            req_if.right_y <= nxt.axis[3];
            req_if.button_bits <= nxt.buttons;
            req_if.left_pull <= nxt.pull[0];
            req_if.right_pull <= nxt.pull[1];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result stall pattern
   always @(posedge clock) begin
      rsp_if.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: predict on accepted requests, track writes, check events
   always @(posedge clock) begin : monitor
      poll_t      seen;
      pad_event_t want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.poll_ok = req_if.poll_ok;
            seen.axis[0] = req_if.left_x;
            seen.axis[1] = req_if.left_y;
            seen.axis[2] = req_if.right_x;
            seen.axis[3] = req_if.right_y;
            seen.buttons = req_if.button_bits;
            seen.pull[0] = req_if.left_pull;
            seen.pull[1] = req_if.right_pull;
            derive_events(seen);
            polls_taken++;
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.idx)
               CSR_DEAD_ZONE: cfg_dead_zone = csr_if.wdata;
               CSR_CHANGE_THRESHOLD: cfg_change_thr = csr_if.wdata;
               CSR_TRIGGER_THRESHOLD: cfg_trigger_thr = csr_if.wdata[7:0];
               default: ;
            endcase
            csr_writes++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_events.size() == 0) begin
               $error("event with nothing outstanding: kind %0d index %0d",
                      rsp_if.event_kind, rsp_if.event_index);
               failures++;
            end else begin
               want = owed_events.pop_front();
               check_field("event_kind", int'(want.kind), int'(rsp_if.event_kind));
               check_field("event_index", int'(want.index), int'(rsp_if.event_index));
               check_field("axis_value", int'($signed(want.value)),
                           int'($signed(rsp_if.axis_value)));
               check_field("pressed", int'(want.pressed), int'(rsp_if.pressed));
               check_field("last_of_poll", int'(want.last), int'(rsp_if.last_of_poll));
               events_checked++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Main sequence: reset, directed polls, then random phases per setting
   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.poll_ok = 1'b0;
      req_if.left_x = '0;
      req_if.left_y = '0;
      req_if.right_x = '0;
      req_if.right_y = '0;
      req_if.button_bits = '0;
      req_if.left_pull = '0;
      req_if.right_pull = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.idx = CSR_DEAD_ZONE;
      csr_if.wdata = '0;
      send_idle_pct = 23;
      recv_idle_pct = 52;
      polls_pushed = 0;
      polls_taken = 0;
      events_checked = 0;
      csr_writes = 0;
      settings_used = 1;
      failures = 0;
      cycle_count = 0;
      cfg_dead_zone = DEAD_ZONE_RESET;
      cfg_change_thr = CHANGE_THRESHOLD_RESET;
      cfg_trigger_thr = TRIGGER_THRESHOLD_RESET;
      pad_connected = 1'b0;
      last_axis = '0;
      last_buttons = '0;
      last_pull = '0;
      gen_last = '0;
      aim_dz = DEAD_ZONE_RESET;
      aim_tt = TRIGGER_THRESHOLD_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Unmapped index must leave the defaults in force
      write_csr(CSR_UNUSED_IDX, 16'hFFFF);

      // Failed poll while disconnected: nothing
      push_poll(mk_poll(0, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00));
      // Everything changes at once on connect
      push_poll(mk_poll(1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF, 8'hFF));
      push_poll(mk_poll(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 8'h00, 8'h00));
      // Disconnect keeps the sample; a second failure is silent
      push_poll(mk_poll(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF));
      push_poll(mk_poll(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF));
      push_poll(mk_poll(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 8'h00, 8'h00));
      // Dead-zone and threshold edges
      push_poll(mk_poll(1, 16'd1638, 16'd1638, 16'd1638, 16'd1638, 16'h0000, 8'h00, 8'h00));
      push_poll(mk_poll(1, 16'd1639, 16'd1639, 16'd1639, 16'd1639, 16'h0000, 8'h00, 8'h00));
      push_poll(mk_poll(1, 16'd1966, 16'd1966, 16'd1966, 16'd1966, 16'h0000, 8'h00, 8'h00));
      push_poll(mk_poll(1, 16'hF999, 16'hF999, 16'hF999, 16'hF999, 16'h0000, 8'h00, 8'h00));
      push_poll(mk_poll(1, 16'hF99A, 16'hF99A, 16'hF99A, 16'hF99A, 16'h0000, 8'h00, 8'h00));
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 8'h00));
      // Triggers just at and above the threshold
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 8'd127, 8'd128));
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 8'd128, 8'd127));
      // Ignored raw bits, then button patterns
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0C00, 8'd128, 8'd127));
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 8'd128, 8'd127));
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hAAAA, 8'd128, 8'd127));
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h1000, 8'd128, 8'd127));
      push_poll(mk_poll(1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0008, 8'd128, 8'd127));
      wait_quiet();

      // Random phases, settings changed between them
      run_phase(35, 0, 0, 0);
      run_phase(30, 32768, 65535, 255);
      send_idle_pct = 52;
      recv_idle_pct = 23;
      run_phase(30, 65535, $urandom_range(0, 65535), $urandom_range(0, 255));
      run_phase(40, $urandom_range(0, 4000), $urandom_range(0, 2000), $urandom_range(0, 255));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(40, DEAD_ZONE_RESET, CHANGE_THRESHOLD_RESET, TRIGGER_THRESHOLD_RESET);
      run_phase(35, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));

      $display("Ran %0d polls through %0d register settings (%0d writes), checked %0d events,",
               polls_taken, settings_used, csr_writes, events_checked);
      $display("with the request and result sides stalling in turn and then free running.");
      if (failures == 0 && owed_events.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
